@@ hdl/sgr_pkg.sv @@
// Shared types, character codes and reset values for the SGR mouse report parser.
// No dependencies; every other file in hdl/ imports this package.
package sgr_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 12;
  localparam int unsigned TIME_WIDTH_DEF  = 32;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned POS_W      = 13;

  localparam logic [15:0] DCLICK_MS_RST = 16'd400;
  localparam logic [3:0]  XJIT_RST      = 4'd1;
  localparam logic [3:0]  YJIT_RST      = 4'd0;

  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_PRESS   = 8'h4D;
  localparam logic [7:0] CH_RELEASE = 8'h6D;
  localparam logic [7:0] CH_DIG0    = 8'h30;
  localparam logic [7:0] CH_DIG9    = 8'h39;
  localparam logic [7:0] FINAL_LO   = 8'h40;
  localparam logic [7:0] FINAL_HI   = 8'h7E;

  localparam logic [7:0] CODE_MOVE_BASE = 8'd32;
  localparam logic [7:0] CODE_RELEASE   = 8'd3;
  localparam logic [7:0] CODE_LEFT      = 8'd0;
  localparam logic [7:0] CODE_MIDDLE    = 8'd1;
  localparam logic [7:0] CODE_RIGHT     = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DCLICK_MS = 2'd0,
    CFG_X_JITTER  = 2'd1,
    CFG_Y_JITTER  = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_ESC   = 5'b00010,
    PH_CSI   = 5'b00100,
    PH_SKIP  = 5'b01000,
    PH_MOUSE = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    FS_CODE = 2'd0,
    FS_COL  = 2'd1,
    FS_ROW  = 2'd2,
    FS_DONE = 2'd3
  } field_stage_e;

  typedef enum logic [2:0] {
    EV_KEY     = 3'd0,
    EV_CLICK   = 3'd1,
    EV_DCLICK  = 3'd2,
    EV_MOVE    = 3'd3,
    EV_RELEASE = 3'd4
  } event_kind_e;

  typedef enum logic [1:0] {
    BTN_NONE   = 2'd0,
    BTN_LEFT   = 2'd1,
    BTN_MIDDLE = 2'd2,
    BTN_RIGHT  = 2'd3
  } button_e;

  typedef struct packed {
    logic key_emit;
    logic mouse_emit;
    logic fin_press;
  } parse_ctl_t;

  typedef struct packed {
    event_kind_e             kind;
    logic [7:0]              key_char;
    button_e                 button;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } event_t;

  function automatic button_e map_button(input logic [7:0] code);
    button_e btn;
    btn = BTN_NONE;
    if (code == CODE_LEFT) btn = BTN_LEFT;
    else if (code == CODE_MIDDLE) btn = BTN_MIDDLE;
    else if (code == CODE_RIGHT) btn = BTN_RIGHT;
    return btn;
  endfunction

  function automatic logic is_final(input logic [7:0] c);
    return (c >= FINAL_LO) && (c <= FINAL_HI);
  endfunction

endpackage

@@ hdl/sgr_mouse_escape_parser_unit.sv @@
// Top level of the SGR mouse report parser: stream ports, config registers,
// input and result registers. Depends on sgr_pkg, sgr_parse and sgr_event.
//
// One terminal byte with its millisecond timestamp enters per beat on the
// s_axis channel. Plain bytes leave as key events (CR becomes LF); complete
// ESC [ < b;x;y M/m reports leave as click, double-click, move or release
// events; bytes inside escape sequences produce no beat on m_axis.
// The event kind travels in m_axis_tuser.
// Flow: an accepted byte sits in the input register, and any event it
// produces is loaded from there into the result register, which drives
// m_axis. Throughput: one byte per cycle, unless a result waiting on m_axis
// blocks a byte that produces an event; the parse step between the input
// register and the result register is combinational.
// Stall: when m_axis_tready is low and a result waits, the input register
// still takes one more byte; s_axis_tready drops only when both registers
// are full and the held byte would produce an event.
// Reset: asynchronous, active low. Parser returns to idle, double-click
// memory is disarmed, config registers return to 400 ms, x jitter 1 and
// y jitter 0. Write config via cfg_we_i only while no beat is in flight.
module sgr_mouse_escape_parser_unit import sgr_pkg::*; #(
  parameter int unsigned CoordWidth = COORD_WIDTH_DEF,
  parameter int unsigned TimeWidth  = TIME_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [39:0]           s_axis_tdata,  // byte_in[7:0], timestamp_ms[39:8]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,  // key_char[7:0], button[9:8],
                                               // pos_x[22:10], pos_y[35:23], zero pad
  output logic [2:0]            m_axis_tuser,  // event_kind[2:0]
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [15:0]           dclick_ms_q;
  logic [3:0]            x_jitter_q;
  logic [3:0]            y_jitter_q;

  logic                  in_vld_q, in_vld_d;
  logic [7:0]            byte_q;
  logic [31:0]           time_q;

  logic                  out_vld_q, out_vld_d;
  event_t                out_q;

  parse_ctl_t            ctl;
  logic [7:0]            key_char;
  logic [7:0]            code;
  logic [CoordWidth-1:0] col;
  logic [CoordWidth-1:0] row;
  event_t                evt;
  logic                  emit;
  logic                  adv;
  logic                  s_acc;

  assign emit          = ctl.key_emit | ctl.mouse_emit;
  assign adv           = in_vld_q && (!emit || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign in_vld_d      = s_acc ? 1'b1 : (adv ? 1'b0 : in_vld_q);
  assign out_vld_d     = (adv && emit) ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dclick_ms_q <= DCLICK_MS_RST;
      x_jitter_q  <= XJIT_RST;
      y_jitter_q  <= YJIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DCLICK_MS: dclick_ms_q <= cfg_data_i[15:0];
        CFG_X_JITTER:  x_jitter_q  <= cfg_data_i[3:0];
        CFG_Y_JITTER:  y_jitter_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      byte_q <= s_axis_tdata[7:0];
      time_q <= s_axis_tdata[39:8];
    end
    if (adv && emit) begin
      out_q <= evt;
    end
  end

  sgr_parse #(
    .CoordWidth(CoordWidth)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_q),
    .commit_i  (adv),
    .ctl_o     (ctl),
    .key_char_o(key_char),
    .code_o    (code),
    .col_o     (col),
    .row_o     (row)
  );

  sgr_event #(
    .CoordWidth(CoordWidth),
    .TimeWidth (TimeWidth)
  ) u_event (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .commit_i   (adv),
    .ctl_i      (ctl),
    .key_char_i (key_char),
    .code_i     (code),
    .col_i      (col),
    .row_i      (row),
    .now_i      (time_q),
    .dclick_ms_i(dclick_ms_q),
    .x_jitter_i (x_jitter_q),
    .y_jitter_i (y_jitter_q),
    .event_o    (evt)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {4'b0000, out_q.pos_y, out_q.pos_x, out_q.button, out_q.key_char};

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q && out_vld_q)
    else $error("input stalled with a free register");

  a_key_no_mouse_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_KEY) |-> (m_axis_tdata[35:8] == '0))
    else $error("key event carries button or position");

  a_mouse_no_key_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != EV_KEY) |-> (m_axis_tdata[7:0] == '0))
    else $error("mouse event carries a key byte");

  a_no_drop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready |-> !(adv && emit))
    else $error("result register overwritten while stalled");
`endif

endmodule

@@ hdl/sgr_parse.sv @@
// Byte-level escape sequence tracker and saturating field accumulators.
// Depends on sgr_pkg.
module sgr_parse import sgr_pkg::*; #(
  parameter int unsigned CoordWidth = COORD_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            byte_i,
  input  logic                  commit_i,
  output parse_ctl_t            ctl_o,
  output logic [7:0]            key_char_o,
  output logic [7:0]            code_o,
  output logic [CoordWidth-1:0] col_o,
  output logic [CoordWidth-1:0] row_o
);

  phase_e                phase_q, phase_d;
  field_stage_e          stage_q, stage_d;
  logic [7:0]            acc_code_q, acc_code_d;
  logic [CoordWidth-1:0] acc_col_q, acc_col_d;
  logic [CoordWidth-1:0] acc_row_q, acc_row_d;

  logic [11:0]           code_ext;
  logic [CoordWidth+3:0] col_ext;
  logic [CoordWidth+3:0] row_ext;
  logic [7:0]            code_sat;
  logic [CoordWidth-1:0] col_sat;
  logic [CoordWidth-1:0] row_sat;
  logic [3:0]            digit;
  logic                  is_digit;
  logic                  plain;

  assign digit    = byte_i[3:0];
  assign is_digit = (byte_i >= CH_DIG0) && (byte_i <= CH_DIG9);

  assign code_ext = 12'({acc_code_q, 3'b000}) + 12'({acc_code_q, 1'b0}) + 12'(digit);
  assign col_ext  = (CoordWidth+4)'({acc_col_q, 3'b000}) + (CoordWidth+4)'({acc_col_q, 1'b0})
                  + (CoordWidth+4)'(digit);
  assign row_ext  = (CoordWidth+4)'({acc_row_q, 3'b000}) + (CoordWidth+4)'({acc_row_q, 1'b0})
                  + (CoordWidth+4)'(digit);

  assign code_sat = (|code_ext[11:8]) ? '1 : code_ext[7:0];
  assign col_sat  = (|col_ext[CoordWidth+3:CoordWidth]) ? '1 : col_ext[CoordWidth-1:0];
  assign row_sat  = (|row_ext[CoordWidth+3:CoordWidth]) ? '1 : row_ext[CoordWidth-1:0];

  always_comb begin
    phase_d    = phase_q;
    stage_d    = stage_q;
    acc_code_d = acc_code_q;
    acc_col_d  = acc_col_q;
    acc_row_d  = acc_row_q;
    ctl_o      = '0;
    plain      = 1'b0;

    unique case (phase_q)
      PH_ESC: begin
        if (byte_i == CH_LBRACK) phase_d = PH_CSI;
        else plain = 1'b1;
      end
      PH_CSI: begin
        if (byte_i == CH_LT) begin
          phase_d    = PH_MOUSE;
          stage_d    = FS_CODE;
          acc_code_d = '0;
          acc_col_d  = '0;
          acc_row_d  = '0;
        end else begin
          phase_d = is_final(byte_i) ? PH_IDLE : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (is_final(byte_i)) phase_d = PH_IDLE;
      end
      PH_MOUSE: begin
        if ((byte_i == CH_PRESS) || (byte_i == CH_RELEASE)) begin
          phase_d          = PH_IDLE;
          ctl_o.mouse_emit = 1'b1;
          ctl_o.fin_press  = (byte_i == CH_PRESS);
        end else if (stage_q != FS_DONE) begin
          if (is_digit) begin
            unique case (stage_q)
              FS_CODE: acc_code_d = code_sat;
              FS_COL:  acc_col_d  = col_sat;
              default: acc_row_d  = row_sat;
            endcase
          end else if (byte_i == CH_SEMI) begin
            stage_d = field_stage_e'(stage_q + 2'd1);
          end else begin
            stage_d = FS_DONE;
          end
        end
      end
      default: plain = 1'b1;
    endcase

    if (plain) begin
      if (byte_i == CH_ESC) begin
        phase_d = PH_ESC;
      end else begin
        phase_d        = PH_IDLE;
        ctl_o.key_emit = 1'b1;
      end
    end
  end

  assign key_char_o = (byte_i == CH_CR) ? CH_LF : byte_i;
  assign code_o     = acc_code_q;
  assign col_o      = acc_col_q;
  assign row_o      = acc_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      stage_q    <= FS_CODE;
      acc_code_q <= '0;
      acc_col_q  <= '0;
      acc_row_q  <= '0;
    end else if (commit_i) begin
      phase_q    <= phase_d;
      stage_q    <= stage_d;
      acc_code_q <= acc_code_d;
      acc_col_q  <= acc_col_d;
      acc_row_q  <= acc_row_d;
    end
  end

endmodule

@@ hdl/sgr_event.sv @@
// Event builder: key events, mouse report decode and double-click memory.
// Depends on sgr_pkg.
module sgr_event import sgr_pkg::*; #(
  parameter int unsigned CoordWidth = COORD_WIDTH_DEF,
  parameter int unsigned TimeWidth  = TIME_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  commit_i,
  input  parse_ctl_t            ctl_i,
  input  logic [7:0]            key_char_i,
  input  logic [7:0]            code_i,
  input  logic [CoordWidth-1:0] col_i,
  input  logic [CoordWidth-1:0] row_i,
  input  logic [31:0]           now_i,
  input  logic [15:0]           dclick_ms_i,
  input  logic [3:0]            x_jitter_i,
  input  logic [3:0]            y_jitter_i,
  output event_t                event_o
);

  logic                         armed_q, armed_d;
  logic [TimeWidth-1:0]         last_time_q, last_time_d;
  logic signed [CoordWidth:0]   last_col_q, last_col_d;
  logic signed [CoordWidth:0]   last_row_q, last_row_d;
  logic [7:0]                   last_code_q, last_code_d;

  logic [TimeWidth-1:0]         now_tw;
  logic [TimeWidth-1:0]         gap;
  logic signed [CoordWidth:0]   pos_x;
  logic signed [CoordWidth:0]   pos_y;
  logic signed [CoordWidth+1:0] dx;
  logic signed [CoordWidth+1:0] dy;
  logic [CoordWidth+1:0]        adx;
  logic [CoordWidth+1:0]        ady;
  logic                         is_move;
  logic                         is_click;
  logic                         dbl;
  event_kind_e                  kind;
  button_e                      btn;

  assign now_tw = TimeWidth'(now_i);
  assign gap    = now_tw - last_time_q;

  assign pos_x = $signed({1'b0, col_i}) - $signed((CoordWidth+1)'(1));
  assign pos_y = $signed({1'b0, row_i}) - $signed((CoordWidth+1)'(1));
  assign dx    = (CoordWidth+2)'(pos_x) - (CoordWidth+2)'(last_col_q);
  assign dy    = (CoordWidth+2)'(pos_y) - (CoordWidth+2)'(last_row_q);
  assign adx   = dx[CoordWidth+1] ? unsigned'(-dx) : unsigned'(dx);
  assign ady   = dy[CoordWidth+1] ? unsigned'(-dy) : unsigned'(dy);

  assign is_move  = (code_i >= CODE_MOVE_BASE);
  assign is_click = !is_move && (code_i != CODE_RELEASE);
  assign dbl      = armed_q && (code_i == last_code_q)
                 && (adx <= (CoordWidth+2)'(x_jitter_i))
                 && (ady <= (CoordWidth+2)'(y_jitter_i))
                 && (gap < TimeWidth'(dclick_ms_i));

  always_comb begin
    kind = EV_RELEASE;
    btn  = BTN_NONE;
    if (ctl_i.fin_press) begin
      if (is_move) begin
        kind = EV_MOVE;
        btn  = map_button(code_i - CODE_MOVE_BASE);
      end else if (is_click) begin
        kind = dbl ? EV_DCLICK : EV_CLICK;
        btn  = map_button(code_i);
      end
    end else if (is_move) begin
      kind = EV_MOVE;
    end
  end

  always_comb begin
    if (ctl_i.mouse_emit) begin
      event_o.kind     = kind;
      event_o.key_char = '0;
      event_o.button   = btn;
      event_o.pos_x    = POS_W'(pos_x);
      event_o.pos_y    = POS_W'(pos_y);
    end else begin
      event_o.kind     = EV_KEY;
      event_o.key_char = key_char_i;
      event_o.button   = BTN_NONE;
      event_o.pos_x    = '0;
      event_o.pos_y    = '0;
    end
  end

  always_comb begin
    armed_d     = armed_q;
    last_time_d = last_time_q;
    last_col_d  = last_col_q;
    last_row_d  = last_row_q;
    last_code_d = last_code_q;
    if (commit_i && ctl_i.mouse_emit && ctl_i.fin_press && is_click) begin
      if (dbl) begin
        armed_d     = 1'b0;
        last_time_d = '0;
      end else begin
        armed_d     = 1'b1;
        last_time_d = now_tw;
        last_col_d  = pos_x;
        last_row_d  = pos_y;
        last_code_d = code_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      last_time_q <= '0;
      last_col_q  <= '1;
      last_row_q  <= '1;
      last_code_q <= '0;
    end else begin
      armed_q     <= armed_d;
      last_time_q <= last_time_d;
      last_col_q  <= last_col_d;
      last_row_q  <= last_row_d;
      last_code_q <= last_code_d;
    end
  end

endmodule
